// ----- rtl/wlvs_pkg.sv -----
package wlvs_pkg;

	// Default number of value slots; the status ring holds one more entry.
	localparam int SLOTS_DEF = 200;

	// Fixed field widths of the channel items.
	localparam int KIND_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int ACTIVE_W = 8;

	// Operation codes carried in the kind field.
	typedef enum logic [KIND_W-1:0] {
		KIND_FORMAT  = 2'd0,
		KIND_RECOVER = 2'd1,
		KIND_WRITE   = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	// One request item.
	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] value;
	} req_item_t;

	// One response item.
	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic                      ok;
		logic [ACTIVE_W-1:0]       active_index;
	} rsp_item_t;

	// Source of the status ring read address.
	typedef enum logic [1:0] {
		SRC_PTR,
		SRC_LAST,
		SRC_CNT
	} st_src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    start;
		logic    st_rd;
		st_src_t st_src;
		logic    val_rd;
		logic    wr_commit;
		logic    fmt_step;
		logic    rec_step;
		logic    out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fmt_last;
		logic rec_hit;
		logic rec_end;
	} dp_sts_t;

endpackage

// ----- rtl/wlvs_datapath.sv -----
module wlvs_datapath #(
	parameter int SLOTS = wlvs_pkg::SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wlvs_pkg::req_item_t req,
	input  wlvs_pkg::dp_cmd_t   cmd_in,
	output wlvs_pkg::dp_sts_t   sts,
	output wlvs_pkg::rsp_item_t rsp
);

	localparam int PTR_W  = $clog2(SLOTS + 1);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 2);

	localparam logic [PTR_W-1:0]  LAST_PTR    = PTR_W'(SLOTS);
	localparam logic [PTR_W-1:0]  PREV_PTR    = PTR_W'(SLOTS - 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0]  CNT_FMT_END = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0]  CNT_REC_END = CNT_W'(SLOTS + 1);

	// Status ring and value ring.
	logic [SLOT_W-1:0]          status_mem [SLOTS+1];
	logic [wlvs_pkg::VALUE_W-1:0] value_mem  [SLOTS];

	logic [PTR_W-1:0]             ptr_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         ok_q;
	logic [wlvs_pkg::KIND_W-1:0]  kind_q;
	logic [wlvs_pkg::VALUE_W-1:0] value_q;
	logic [SLOT_W-1:0]            prev_q;
	logic [SLOT_W-1:0]            st_rdata_q;
	logic [wlvs_pkg::VALUE_W-1:0] val_rdata_q;
	wlvs_pkg::rsp_item_t          rsp_q;

	logic [PTR_W-1:0]  st_raddr;
	logic              st_rd_go;
	logic [SLOT_W-1:0] slot_next;
	logic [PTR_W-1:0]  ptr_next;
	logic [PTR_W-1:0]  rec_ptr;
	logic              st_we;
	logic [PTR_W-1:0]  st_waddr;
	logic [SLOT_W-1:0] st_wdata;
	logic              val_we;
	logic [SLOT_W-1:0] val_waddr;

	// Status back to the controller.
	always_comb begin
		sts.fmt_last = (cnt_q == CNT_FMT_END);
		sts.rec_hit  = (cnt_q != '0) && (st_rdata_q == prev_q);
		sts.rec_end  = (cnt_q == CNT_REC_END);
	end

	// Status read address; the scan stops reading past the last entry.
	always_comb begin
		unique case (cmd_in.st_src)
			wlvs_pkg::SRC_PTR:  st_raddr = ptr_q;
			wlvs_pkg::SRC_LAST: st_raddr = LAST_PTR;
			wlvs_pkg::SRC_CNT:  st_raddr = cnt_q[PTR_W-1:0];
			default:            st_raddr = ptr_q;
		endcase
		st_rd_go = cmd_in.st_rd &&
			((cmd_in.st_src != wlvs_pkg::SRC_CNT) || (cnt_q <= CNT_FMT_END));
	end

	// Next slot and next pointer for a write, and the pointer a recover hit gives.
	always_comb begin
		slot_next = (st_rdata_q == LAST_SLOT) ? '0 : st_rdata_q + 1'b1;
		ptr_next  = (ptr_q == LAST_PTR) ? '0 : ptr_q + 1'b1;
		rec_ptr   = (cnt_q == CNT_W'(1)) ? LAST_PTR : PTR_W'(cnt_q - CNT_W'(2));
	end

	// Write ports: the format sweep or a committed write.
	always_comb begin
		st_we     = cmd_in.wr_commit || cmd_in.fmt_step;
		st_waddr  = cmd_in.fmt_step ? cnt_q[PTR_W-1:0] : ptr_next;
		st_wdata  = cmd_in.fmt_step ?
			((cnt_q == CNT_FMT_END) ? '0 : cnt_q[SLOT_W-1:0]) : slot_next;
		val_we    = cmd_in.wr_commit || (cmd_in.fmt_step && (cnt_q == '0));
		val_waddr = cmd_in.fmt_step ? '0 : slot_next;
	end

	// Status ring memory.
	always_ff @(posedge clk) begin
		if (st_we) begin
			status_mem[st_waddr] <= st_wdata;
		end
		if (st_rd_go) begin
			st_rdata_q <= status_mem[st_raddr];
		end
	end

	// Value ring memory.
	always_ff @(posedge clk) begin
		if (val_we) begin
			value_mem[val_waddr] <= value_q;
		end
		if (cmd_in.val_rd) begin
			val_rdata_q <= value_mem[st_rdata_q];
		end
	end

	// Pointer, sweep counter and recover flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= LAST_PTR;
			cnt_q <= '0;
			ok_q  <= 1'b1;
		end else begin
			if (cmd_in.start) begin
				cnt_q <= '0;
			end else if (cmd_in.fmt_step || cmd_in.rec_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd_in.wr_commit) begin
				ptr_q <= ptr_next;
			end
			if (cmd_in.rec_step) begin
				if (sts.rec_hit) begin
					ptr_q <= rec_ptr;
					ok_q  <= 1'b1;
				end else if (sts.rec_end) begin
					ptr_q <= PREV_PTR;
					ok_q  <= 1'b0;
				end
			end
		end
	end

	// Item payload, scan predecessor and the response register.
	always_ff @(posedge clk) begin
		if (cmd_in.start) begin
			kind_q  <= req.kind;
			value_q <= req.value;
		end
		if (cmd_in.rec_step && !sts.rec_hit) begin
			prev_q <= st_rdata_q;
		end
		if (cmd_in.out_load) begin
			rsp_q.read_value   <= (kind_q == wlvs_pkg::KIND_READ) ? val_rdata_q : '0;
			rsp_q.ok           <= (kind_q == wlvs_pkg::KIND_RECOVER) ? ok_q : 1'b1;
			rsp_q.active_index <= wlvs_pkg::ACTIVE_W'(ptr_q);
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- rtl/wlvs_ctrl.sv -----
module wlvs_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [wlvs_pkg::KIND_W-1:0] req_kind,
	output logic                        req_stall,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  wlvs_pkg::dp_sts_t           sts,
	output wlvs_pkg::dp_cmd_t           cmd_out
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_VAL,
		S_WR,
		S_FMT,
		S_REC,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   accept;
	logic   out_free;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Commands for the current state and the next state.
	always_comb begin
		cmd_out        = '0;
		cmd_out.st_src = wlvs_pkg::SRC_PTR;
		state_d        = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_out.start = 1'b1;
					cmd_out.st_rd = 1'b1;
					unique case (req_kind)
						wlvs_pkg::KIND_FORMAT: state_d = S_FMT;
						wlvs_pkg::KIND_RECOVER: begin
							cmd_out.st_src = wlvs_pkg::SRC_LAST;
							state_d        = S_REC;
						end
						wlvs_pkg::KIND_WRITE: state_d = S_WR;
						default:              state_d = S_VAL;
					endcase
				end
			end
			S_VAL: begin
				cmd_out.val_rd = 1'b1;
				state_d        = S_FIN;
			end
			S_WR: begin
				cmd_out.wr_commit = 1'b1;
				state_d           = S_FIN;
			end
			S_FMT: begin
				cmd_out.fmt_step = 1'b1;
				if (sts.fmt_last) begin
					state_d = S_FIN;
				end
			end
			S_REC: begin
				cmd_out.rec_step = 1'b1;
				cmd_out.st_rd    = 1'b1;
				cmd_out.st_src   = wlvs_pkg::SRC_CNT;
				if (sts.rec_hit || sts.rec_end) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd_out.out_load = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_out.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/wear_leveled_value_store_unit.sv -----
// Channel  Handshake            Payload
// req      req_valid/req_stall  wlvs_pkg::req_item_t  (kind, value)
// rsp      rsp_valid/rsp_stall  wlvs_pkg::rsp_item_t  (read_value, ok, active_index)
//
// One item is handled at a time; req_stall is high from acceptance until the
// response is loaded. Read and write pass through status read, value access
// and response load. Format and recover each make one pass over the status
// ring through its single read or write port. Reset clears control state and
// sets the active pointer to SLOTS; both rings hold nothing valid until a
// format. A stalled response holds the next item.
module wear_leveled_value_store_unit #(
	parameter int SLOTS = wlvs_pkg::SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  wlvs_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output wlvs_pkg::rsp_item_t rsp
);

	wlvs_pkg::dp_cmd_t dp_cmd;
	wlvs_pkg::dp_sts_t dp_sts;

	// Operation sequencer.
	wlvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_kind  (req.kind),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (dp_sts),
		.cmd_out   (dp_cmd)
	);

	// Rings, pointer and response register.
	wlvs_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd_in (dp_cmd),
		.sts    (dp_sts),
		.rsp    (rsp)
	);

	// An accepted item blocks the next one until its response is loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while an item is in progress");

	// The active pointer never leaves the status ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.active_index <= wlvs_pkg::ACTIVE_W'(SLOTS)))
		else $error("active index beyond the status ring");

	// A failed recover never carries read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> (rsp.read_value == '0))
		else $error("read data on a failed recover");

endmodule

// ----- tb/wear_leveled_value_store_unit_tb.sv -----
`timescale 1ns / 1ps

module wear_leveled_value_store_unit_tb;

	localparam int SLOTS = wlvs_pkg::SLOTS_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1320;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	wlvs_pkg::req_item_t req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	wlvs_pkg::rsp_item_t rsp;

	// Mirror of the store contents, updated as each item is accepted.
	logic [7:0]  status_m [0:SLOTS];
	logic [31:0] value_m [0:SLOTS-1];
	bit          written_m [0:SLOTS-1];
	int unsigned pointer_m = SLOTS;

	wlvs_pkg::rsp_item_t pending_rsp [$];
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;
	bit          calm = 1'b0;
	int unsigned hold_asks = 0;
	int unsigned hold_taken = 0;
	int unsigned hold_left = 0;

	wear_leveled_value_store_unit #(
		.SLOTS(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	// Applies one operation to the mirrored store and returns the response it must give.
	function automatic wlvs_pkg::rsp_item_t step_store(input wlvs_pkg::req_item_t item);
		wlvs_pkg::rsp_item_t res;
		int unsigned         slot;
		int unsigned         prev;
		bit                  found;
		res.read_value = '0;
		res.ok = 1'b1;
		case (wlvs_pkg::kind_t'(item.kind))
			wlvs_pkg::KIND_FORMAT: begin
				for (int i = 0; i <= SLOTS; i++)
					status_m[i] = 8'(i % SLOTS);
				value_m[0] = item.value;
				written_m[0] = 1'b1;
			end
			wlvs_pkg::KIND_RECOVER: begin
				// The last status entry precedes the first one in the scan.
				prev = status_m[SLOTS];
				found = 1'b0;
				for (int i = 0; i <= SLOTS && !found; i++) begin
					if (status_m[i] == prev) begin
						pointer_m = (i == 0) ? SLOTS : i - 1;
						found = 1'b1;
					end
					prev = status_m[i];
				end
				if (!found)
					pointer_m = SLOTS - 1;
				res.ok = found;
			end
			wlvs_pkg::KIND_WRITE: begin
				slot = (status_m[pointer_m] % SLOTS + 1) % SLOTS;
				pointer_m = (pointer_m + 1) % (SLOTS + 1);
				value_m[slot] = item.value;
				written_m[slot] = 1'b1;
				status_m[pointer_m] = 8'(slot);
			end
			default: begin
				res.read_value = value_m[status_m[pointer_m] % SLOTS];
			end
		endcase
		res.active_index = 8'(pointer_m);
		return res;
	endfunction

	// A read is only issued when the slot it would return has been written.
	function automatic wlvs_pkg::kind_t read_or_write();
		return written_m[status_m[pointer_m] % SLOTS] ?
			wlvs_pkg::KIND_READ : wlvs_pkg::KIND_WRITE;
	endfunction

	// Offers one item, with random idle cycles ahead of it, and waits until it is taken.
	task automatic send_op(input wlvs_pkg::kind_t kind, input logic [31:0] value);
		wlvs_pkg::req_item_t item;
		item.kind = kind;
		item.value = value;
		while (!calm && $urandom_range(0, 99) < 36) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(step_store(item));
		@(negedge clk);
	endtask

	// Format with extreme values, each followed by a read of slot zero.
	task automatic test_format_extremes();
		send_op(wlvs_pkg::KIND_FORMAT, 32'h8000_0000);
		send_op(read_or_write(), 32'h0);
		send_op(wlvs_pkg::KIND_FORMAT, 32'h7FFF_FFFF);
		send_op(read_or_write(), 32'h0);
		send_op(wlvs_pkg::KIND_FORMAT, 32'h0000_0000);
		send_op(read_or_write(), 32'h0);
	endtask

	// Writes of extreme and alternating bit patterns, each but 5555_5555 read back.
	task automatic test_write_read();
		send_op(wlvs_pkg::KIND_WRITE, 32'hFFFF_FFFF);
		send_op(read_or_write(), 32'h0);
		send_op(wlvs_pkg::KIND_WRITE, 32'h0000_0001);
		send_op(read_or_write(), 32'h0);
		send_op(wlvs_pkg::KIND_WRITE, 32'h5555_5555);
		send_op(wlvs_pkg::KIND_WRITE, 32'hAAAA_AAAA);
		send_op(read_or_write(), 32'h0);
	endtask

	// Pointer recovery from the status ring, before and after a write.
	task automatic test_recover();
		send_op(wlvs_pkg::KIND_RECOVER, 32'h0);
		send_op(read_or_write(), 32'h0);
		send_op(wlvs_pkg::KIND_WRITE, 32'h1234_5678);
		send_op(wlvs_pkg::KIND_RECOVER, 32'hFFFF_FFFF);
		send_op(read_or_write(), 32'h0);
	endtask

	// Format while the pointer sits inside the ring, then use and recover it.
	task automatic test_format_midring();
		send_op(wlvs_pkg::KIND_FORMAT, 32'hDEAD_BEEF);
		send_op(read_or_write(), 32'h0);
		send_op(wlvs_pkg::KIND_WRITE, 32'hFFFF_FFFE);
		send_op(read_or_write(), 32'h0);
		send_op(wlvs_pkg::KIND_RECOVER, 32'h0);
		send_op(read_or_write(), 32'h0);
	endtask

	// The receiver holds off for a long stretch while items keep coming.
	task automatic test_output_hold();
		calm = 1'b1;
		hold_asks++;
		for (int n = 0; n < 8; n++)
			send_op((n % 2) ? read_or_write() : wlvs_pkg::KIND_WRITE, $urandom());
		calm = 1'b0;
	endtask

	// Mostly writes and reads so the pointer wraps, with some formats and recovers.
	task automatic test_random_mix(input int unsigned count);
		wlvs_pkg::kind_t kind;
		int unsigned     roll;
		for (int unsigned n = 0; n < count; n++) begin
			calm = (n < count / 4);
			roll = $urandom_range(0, 99);
			if (roll < 3)
				kind = wlvs_pkg::KIND_FORMAT;
			else if (roll < 10)
				kind = wlvs_pkg::KIND_RECOVER;
			else if (roll < 55)
				kind = wlvs_pkg::KIND_WRITE;
			else
				kind = read_or_write();
			send_op(kind, $urandom());
		end
		calm = 1'b0;
	endtask

	// Receiver stall: a long hold when asked for, otherwise random.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (hold_taken != hold_asks) begin
			hold_taken = hold_asks;
			hold_left = HOLD_CYCLES - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !calm && ($urandom_range(0, 99) < 36);
		end
	end

	// Compare each accepted response with the oldest expected one.
	always @(posedge clk) begin : rsp_check
		wlvs_pkg::rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("response item with none expected: %h", rsp);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
					fail_count++;
				end
				if (rsp.ok !== want.ok) begin
					$error("ok: expected %0b, got %0b", want.ok, rsp.ok);
					fail_count++;
				end
				if (rsp.active_index !== want.active_index) begin
					$error("active_index: expected %0d, got %0d",
						want.active_index, rsp.active_index);
					fail_count++;
				end
			end
		end
	end

	// Ends the run when no item moves on either side for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_format_extremes();
		test_write_read();
		test_recover();
		test_format_midring();
		test_output_hold();
		test_random_mix(RANDOM_ITEMS);
		req_valid <= 1'b0;
		// Drain, then leave time for any stray response.
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/wlvs_pkg.sv
rtl/wlvs_datapath.sv
rtl/wlvs_ctrl.sv
rtl/wear_leveled_value_store_unit.sv
tb/wear_leveled_value_store_unit_tb.sv
